[hw/rtl/hlat_pkg.sv]
// Shared types, register codes and helpers for the host liveness alarm throttle.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package hlat_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DOWN_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UP_THRESHOLD   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BAN_START      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BAN_END        = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIER_ONE_LAST  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TIER_ONE_SPAN  = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIER_TWO_LAST  = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TIER_TWO_SPAN  = 8'd7;

    // Register reset values.
    localparam logic [7:0]  DOWN_THRESHOLD_RST = 8'd3;
    localparam logic [7:0]  UP_THRESHOLD_RST   = 8'd2;
    localparam logic [31:0] BAN_START_RST      = 32'd0;
    localparam logic [31:0] BAN_END_RST        = 32'd0;
    localparam logic [7:0]  TIER_ONE_LAST_RST  = 8'd5;
    localparam logic [31:0] TIER_ONE_SPAN_RST  = 32'd300;
    localparam logic [7:0]  TIER_TWO_LAST_RST  = 8'd10;
    localparam logic [31:0] TIER_TWO_SPAN_RST  = 32'd900;

    // Repeat interval once the alarm count is past both tiers: one hour.
    localparam logic [31:0] FALLBACK_SPAN = 32'd3600;

    // Status change codes.
    localparam logic [1:0] CHG_NONE = 2'd0;
    localparam logic [1:0] CHG_DOWN = 2'd1;
    localparam logic [1:0] CHG_UP   = 2'd2;

    typedef struct packed {
        logic        metric_seen;
        logic        ping_ok;
        logic [31:0] now_seconds;
    } hlat_in_t;

    typedef struct packed {
        logic [1:0]  status_change;
        logic        alarm_sent;
        logic        host_is_up;
        logic        banned;
        logic [7:0]  alarms_so_far;
        logic [31:0] outage_start;
    } hlat_out_t;

    typedef struct packed {
        logic [7:0]  down_threshold;
        logic [7:0]  up_threshold;
        logic [31:0] ban_start;
        logic [31:0] ban_end;
        logic [7:0]  tier_one_last;
        logic [31:0] tier_one_span;
        logic [7:0]  tier_two_last;
        logic [31:0] tier_two_span;
    } hlat_cfg_t;

    typedef struct packed {
        logic        up_flag;
        logic [7:0]  fail_count;
        logic [7:0]  good_count;
        logic [7:0]  alarm_total;
        logic [31:0] last_alarm_at;
        logic [31:0] first_alarm_at;
    } hlat_state_t;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hlat_regs.sv]
// Configuration register file of the host liveness alarm throttle.
// Depends on hlat_pkg for register indexes, reset values and hlat_cfg_t.
`default_nettype none

module hlat_regs
    import hlat_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output hlat_cfg_t                   cfg
);

    hlat_cfg_t cfg_reg;
    hlat_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_DOWN_THRESHOLD: cfg_next.down_threshold = wr_data[7:0];
                REG_UP_THRESHOLD:   cfg_next.up_threshold   = wr_data[7:0];
                REG_BAN_START:      cfg_next.ban_start      = wr_data;
                REG_BAN_END:        cfg_next.ban_end        = wr_data;
                REG_TIER_ONE_LAST:  cfg_next.tier_one_last  = wr_data[7:0];
                REG_TIER_ONE_SPAN:  cfg_next.tier_one_span  = wr_data;
                REG_TIER_TWO_LAST:  cfg_next.tier_two_last  = wr_data[7:0];
                REG_TIER_TWO_SPAN:  cfg_next.tier_two_span  = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.down_threshold <= DOWN_THRESHOLD_RST;
            cfg_reg.up_threshold   <= UP_THRESHOLD_RST;
            cfg_reg.ban_start      <= BAN_START_RST;
            cfg_reg.ban_end        <= BAN_END_RST;
            cfg_reg.tier_one_last  <= TIER_ONE_LAST_RST;
            cfg_reg.tier_one_span  <= TIER_ONE_SPAN_RST;
            cfg_reg.tier_two_last  <= TIER_TWO_LAST_RST;
            cfg_reg.tier_two_span  <= TIER_TWO_SPAN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/hlat_step.sv]
// Per-tick decision logic: up/down qualification, ban window and repeat alarm throttling.
// Depends on hlat_pkg for the payload, state and configuration types.
`default_nettype none

module hlat_step
    import hlat_pkg::*;
(
    input  wire hlat_cfg_t   cfg,
    input  wire hlat_state_t st,
    input  wire hlat_in_t    item,
    output hlat_state_t      st_next,
    output hlat_out_t        res
);

    logic        alive;
    logic        ban;
    logic [7:0]  fail_inc;
    logic [7:0]  good_inc;
    logic [31:0] span;
    logic [32:0] due;
    logic        repeat_due;
    logic [1:0]  change;
    logic        sent;

    assign alive    = item.metric_seen | item.ping_ok;
    assign fail_inc = sat_inc8(st.fail_count);
    assign good_inc = sat_inc8(st.good_count);

    // A zero end of the window leaves that side open; both zero disables the ban.
    always_comb begin
        if (cfg.ban_start == '0 && cfg.ban_end == '0) begin
            ban = 1'b0;
        end else if (cfg.ban_end == '0) begin
            ban = (item.now_seconds >= cfg.ban_start);
        end else if (cfg.ban_start == '0) begin
            ban = (item.now_seconds <= cfg.ban_end);
        end else begin
            ban = (item.now_seconds >= cfg.ban_start) && (item.now_seconds <= cfg.ban_end);
        end
    end

    always_comb begin
        if (st.alarm_total == '0) begin
            span = '0;
        end else if (st.alarm_total <= cfg.tier_one_last) begin
            span = cfg.tier_one_span;
        end else if (st.alarm_total <= cfg.tier_two_last) begin
            span = cfg.tier_two_span;
        end else begin
            span = FALLBACK_SPAN;
        end
    end

    // The sum is kept one bit wider so that an overflowing deadline is never reached.
    assign due        = {1'b0, st.last_alarm_at} + {1'b0, span};
    assign repeat_due = ({1'b0, item.now_seconds} >= due);

    always_comb begin
        st_next = st;
        change  = CHG_NONE;
        sent    = 1'b0;
        if (st.up_flag) begin
            if (alive) begin
                st_next.good_count = good_inc;
                st_next.fail_count = '0;
            end else begin
                st_next.fail_count = fail_inc;
                st_next.good_count = '0;
                if (fail_inc >= cfg.down_threshold) begin
                    st_next.up_flag = 1'b0;
                    change          = CHG_DOWN;
                    if (!ban) begin
                        st_next.first_alarm_at = item.now_seconds;
                        st_next.last_alarm_at  = item.now_seconds;
                        st_next.alarm_total    = sat_inc8(st.alarm_total);
                        sent                   = 1'b1;
                    end
                end
            end
        end else begin
            if (alive) begin
                st_next.good_count = good_inc;
                st_next.fail_count = '0;
                if (good_inc >= cfg.up_threshold) begin
                    st_next.up_flag        = 1'b1;
                    change                 = CHG_UP;
                    sent                   = !ban;
                    st_next.alarm_total    = '0;
                    st_next.last_alarm_at  = '0;
                    st_next.first_alarm_at = '0;
                end
            end else begin
                st_next.fail_count = fail_inc;
                if (!ban && repeat_due) begin
                    st_next.last_alarm_at = item.now_seconds;
                    st_next.alarm_total   = sat_inc8(st.alarm_total);
                    sent                  = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res.status_change = change;
        res.alarm_sent    = sent;
        res.host_is_up    = st_next.up_flag;
        res.banned        = ban;
        res.alarms_so_far = st_next.alarm_total;
        res.outage_start  = st_next.first_alarm_at;
    end

endmodule

`default_nettype wire

[hw/rtl/host_liveness_alarm_throttle.sv]
// Top level of the host liveness alarm throttle.
// Depends on hlat_pkg, hlat_regs and hlat_step.
`default_nettype none

// Each accepted request is one check tick and yields exactly one result. A tick is
// captured in an input register, decided by the combinational step logic against the
// stored host state, and the result lands in an output register. One request can be
// taken every cycle while the output register is empty or being drained. The state
// update of a tick and the loading of its result happen together, so ticks are always
// judged in arrival order. Configuration writes are taken in any cycle and should
// only be issued while no tick is in flight.

module host_liveness_alarm_throttle
    import hlat_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire hlat_in_t               s_data,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output hlat_out_t                   m_data,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    hlat_cfg_t   cfg;
    hlat_state_t st_reg;
    hlat_state_t st_next;
    hlat_state_t st_step;
    hlat_out_t   res;

    logic        in_vld_reg;
    hlat_in_t    in_data_reg;
    logic        out_vld_reg;
    hlat_out_t   out_data_reg;
    logic        advance;

    assign cfg_ready = 1'b1;

    hlat_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hlat_step u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_data_reg),
        .st_next (st_step),
        .res     (res)
    );

    // A held tick moves on when the output register is empty or being drained.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign st_next = advance ? st_step : st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg            <= 1'b0;
            out_vld_reg           <= 1'b0;
            st_reg.up_flag        <= 1'b1;
            st_reg.fail_count     <= '0;
            st_reg.good_count     <= '0;
            st_reg.alarm_total    <= '0;
            st_reg.last_alarm_at  <= '0;
            st_reg.first_alarm_at <= '0;
        end else begin
            st_reg <= st_next;
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/hlat_checker.sv]
// Port-level checks for the host liveness alarm throttle, bound to its top level.
// Depends on hlat_pkg for the result type and status change codes.
`default_nettype none

module hlat_checker
    import hlat_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire hlat_out_t m_data
);

    // A stalled result must not move.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The reported transition agrees with the host state it leaves behind.
    a_change_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status_change == CHG_NONE) ||
                    (m_data.status_change == CHG_DOWN && !m_data.host_is_up) ||
                    (m_data.status_change == CHG_UP && m_data.host_is_up))
        else $error("status change disagrees with host state");

    // While the host is up the alarm record is always clear.
    a_up_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.host_is_up |->
            m_data.alarms_so_far == '0 && m_data.outage_start == '0)
        else $error("alarm record not cleared while host is up");

    // No alarm inside the ban window.
    a_ban_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.banned |-> !m_data.alarm_sent)
        else $error("alarm sent inside ban window");

endmodule

bind host_liveness_alarm_throttle hlat_checker u_hlat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
